// File: rtl/incremental_pid_clamped_assert.svh
// assertion macros for the incremental pid controller
`ifndef INCREMENTAL_PID_CLAMPED_ASSERT_SVH
`define INCREMENTAL_PID_CLAMPED_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ipc_pkg.sv
// shared types and constants for the incremental pid controller
package ipc_pkg;

  localparam int RATE_W  = 16;
  localparam int GAIN_W  = 24;
  localparam int ERR_W   = 17;
  localparam int D1_W    = 18;
  localparam int D2_W    = 19;
  localparam int PP_W    = D1_W + GAIN_W + 1;
  localparam int PI_W    = ERR_W + GAIN_W + 1;
  localparam int PD_W    = D2_W + GAIN_W + 1;
  localparam int ACC_W   = 48;
  localparam int TOT_W   = ACC_W + 2;
  localparam int DRIVE_W = 15;
  localparam int FRAC_DROP = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register indexes
  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd2;

  // reset gains, Q8.16
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd393216;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd655;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd196608;

  // limits in Q.26
  localparam logic signed [ACC_W:0]   ACC_MAX   = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W:0]   ACC_MIN   = -ACC_MAX;
  localparam logic signed [ACC_W:0]   INTEG_MAX = 49'sd335544320;
  localparam logic signed [ACC_W:0]   INTEG_MIN = -INTEG_MAX;
  localparam logic signed [TOT_W-1:0] OUT_MAX   = 50'sd671088640;
  localparam logic signed [TOT_W-1:0] OUT_MIN   = -OUT_MAX;
  localparam logic signed [TOT_W-1:0] ROUND_HALF = 50'sd32768;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 15'sd10240;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -15'sd10240;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
  } ipc_gains_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [D1_W-1:0]  d1;
    logic signed [D2_W-1:0]  d2;
  } ipc_err_t;

  typedef struct packed {
    logic signed [PP_W-1:0] p;
    logic signed [PI_W-1:0] i;
    logic signed [PD_W-1:0] d;
  } ipc_prod_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] prop_sum;
    logic signed [ACC_W-1:0] integ_sum;
    logic signed [ACC_W-1:0] deriv_sum;
  } ipc_acc_t;

  // add to an accumulator and clamp to [lo, hi]
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [ACC_W:0]   inc,
    input logic signed [ACC_W:0]   lo,
    input logic signed [ACC_W:0]   hi
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(acc) + inc;
    if (s > hi) begin
      s = hi;
    end else if (s < lo) begin
      s = lo;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

// File: rtl/incremental_pid_clamped.sv
// Incremental (velocity-form) PID controller with clamped integral and output.
// Input channel: in_valid/in_ready carries measured_rate and target_rate
// (signed Q6.10); output channel: out_valid/out_ready carries drive_rate
// (signed Q5.10, within +-10.0). Every input transaction gives exactly one result.
// Gains (unsigned Q8.16) sit on an APB port: prop_gain at 0x0, integ_gain at
// 0x4, deriv_gain at 0x8; write them only while no transaction is in flight.
// A result passes four register stages, error, multiply, accumulate and
// output register, between the edge that accepts its input and out_valid;
// a stall can hold it in any of them.
// Throughput: one transaction per cycle while out_ready stays high; the
// accumulator update (one 48-bit add and clamp per term) closes its loop through the accumulator registers.
// Each stage holds its own transaction; when the receiver stalls, the stages
// fill up one by one and in_ready drops only once all four are occupied.
// Reset (rst, synchronous) clears the error history, the three accumulators
// and all valid flags, and restores the default gains 6.0, 0.01 and 3.0.
module incremental_pid_clamped
  import ipc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // apb configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [RATE_W-1:0]  measured_rate,
  input  logic signed [RATE_W-1:0]  target_rate,
  // output channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DRIVE_W-1:0] drive_rate
);

  ipc_gains_t gains;
  ipc_err_t   err_data;
  ipc_prod_t  prod_data;
  ipc_acc_t   acc_data;
  logic       err_valid;
  logic       err_ready;
  logic       prod_valid;
  logic       prod_ready;
  logic       acc_valid;
  logic       acc_ready;
  logic       cfg_write;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop_gain  <= PROP_GAIN_RST;
      gains.integ_gain <= INTEG_GAIN_RST;
      gains.deriv_gain <= DERIV_GAIN_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PROP_GAIN:  gains.prop_gain  <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: gains.integ_gain <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: gains.deriv_gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_PROP_GAIN:  prdata = DATA_W'(gains.prop_gain);
      REG_INTEG_GAIN: prdata = DATA_W'(gains.integ_gain);
      REG_DERIV_GAIN: prdata = DATA_W'(gains.deriv_gain);
      default:        prdata = '0;
    endcase
  end

  // datapath stages
  ipc_error u_error (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .measured_rate (measured_rate),
    .target_rate   (target_rate),
    .out_valid     (err_valid),
    .out_ready     (err_ready),
    .out_data      (err_data)
  );

  ipc_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_data   (err_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  ipc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (acc_valid),
    .out_ready (acc_ready),
    .out_data  (acc_data)
  );

  ipc_output u_output (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (acc_valid),
    .in_ready   (acc_ready),
    .in_data    (acc_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_rate (drive_rate)
  );

  // checks
`include "incremental_pid_clamped_assert.svh"

  `IPC_ASSERT_NOW(a_drive_range, clk, rst, out_valid,
    (drive_rate <= DRIVE_MAX) && (drive_rate >= DRIVE_MIN), "drive_rate out of range")
  `IPC_ASSERT_NOW(a_integ_limit, clk, rst, 1'b1,
    ((ACC_W+1)'(acc_data.integ_sum) <= INTEG_MAX) &&
    ((ACC_W+1)'(acc_data.integ_sum) >= INTEG_MIN), "integral accumulator past limit")
  `IPC_ASSERT_NEXT(a_acc_hold, clk, rst, acc_valid && !acc_ready,
    $stable(acc_data) && acc_valid, "accumulators moved while stage stalled")

endmodule

// File: rtl/ipc_error.sv
// error stage: error, first and second differences, error history
module ipc_error
  import ipc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [RATE_W-1:0] measured_rate,
  input  logic signed [RATE_W-1:0] target_rate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ipc_err_t                 out_data
);

  logic signed [ERR_W-1:0] last_error;
  logic signed [ERR_W-1:0] older_error;
  logic signed [ERR_W-1:0] err_now;
  logic signed [D1_W-1:0]  d1_now;
  logic signed [D2_W-1:0]  d2_now;
  logic                    accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // error and its differences against the two previous errors
  always_comb begin
    err_now = ERR_W'(target_rate) - ERR_W'(measured_rate);
    d1_now  = D1_W'(err_now) - D1_W'(last_error);
    d2_now  = D2_W'(err_now) - (D2_W'(last_error) <<< 1) + D2_W'(older_error);
  end

  // history and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error  <= '0;
      older_error <= '0;
      out_valid   <= 1'b0;
    end else if (accept) begin
      last_error  <= err_now;
      older_error <= last_error;
      out_valid   <= 1'b1;
    end else if (out_ready) begin
      out_valid   <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.err <= err_now;
      out_data.d1  <= d1_now;
      out_data.d2  <= d2_now;
    end
  end

endmodule

// File: rtl/ipc_mult.sv
// multiply stage: gain times error terms
module ipc_mult
  import ipc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ipc_gains_t gains,
  input  logic       in_valid,
  output logic       in_ready,
  input  ipc_err_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ipc_prod_t  out_data
);

  logic signed [GAIN_W:0] kp;
  logic signed [GAIN_W:0] ki;
  logic signed [GAIN_W:0] kd;
  logic                   accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // gains are unsigned, widen by one zero bit
  assign kp = $signed({1'b0, gains.prop_gain});
  assign ki = $signed({1'b0, gains.integ_gain});
  assign kd = $signed({1'b0, gains.deriv_gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // three independent products
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.p <= PP_W'(in_data.d1) * PP_W'(kp);
      out_data.i <= PI_W'(in_data.err) * PI_W'(ki);
      out_data.d <= PD_W'(in_data.d2) * PD_W'(kd);
    end
  end

endmodule

// File: rtl/ipc_accum.sv
// accumulator stage: three saturating accumulators
module ipc_accum
  import ipc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ipc_prod_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ipc_acc_t  out_data
);

  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // accumulators update once per transaction and double as the stage payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_data  <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      out_data.prop_sum  <= sat_add(out_data.prop_sum, (ACC_W+1)'(in_data.p),
                                    ACC_MIN, ACC_MAX);
      out_data.integ_sum <= sat_add(out_data.integ_sum, (ACC_W+1)'(in_data.i),
                                    INTEG_MIN, INTEG_MAX);
      out_data.deriv_sum <= sat_add(out_data.deriv_sum, (ACC_W+1)'(in_data.d),
                                    ACC_MIN, ACC_MAX);
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/ipc_output.sv
// output stage: total, clamp to +-10, round to q5.10, result register
module ipc_output
  import ipc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ipc_acc_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DRIVE_W-1:0] drive_rate
);

  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] clamped;
  logic signed [TOT_W-1:0] rounded;
  logic signed [TOT_W-1:0] shifted;
  logic                    accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // sum, clamp, round half up
  always_comb begin
    total = TOT_W'(in_data.prop_sum) + TOT_W'(in_data.integ_sum)
          + TOT_W'(in_data.deriv_sum);
    if (total > OUT_MAX) begin
      clamped = OUT_MAX;
    end else if (total < OUT_MIN) begin
      clamped = OUT_MIN;
    end else begin
      clamped = total;
    end
    rounded = clamped + ROUND_HALF;
    shifted = rounded >>> FRAC_DROP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_rate <= shifted[DRIVE_W-1:0];
    end
  end

endmodule
